// ===== hdl/csde_pkg.sv =====
// ----------------------------------------------------------------------------
// csde_pkg: shared types and constants of the divider register encoder
// Holds the cell payload, the beat order of one run and the fixed device codes.
// ----------------------------------------------------------------------------
`default_nettype none

package csde_pkg;

  localparam int unsigned NUM_W = 20;           // numerator and denominator width
  localparam int unsigned INT_W = 11;           // integer part width
  localparam int unsigned FRAC_SH = 7;          // numerator is scaled by 128
  localparam int unsigned QD_W = NUM_W + FRAC_SH; // dividend and quotient width
  localparam int unsigned NUM_CELLS = QD_W;     // one quotient bit per cell
  localparam int unsigned P1_W = 18;

  localparam logic [P1_W-1:0] P1_OFFSET   = 18'd512;
  localparam logic [7:0]      PLL_A_BASE  = 8'd26;
  localparam logic [7:0]      PLL_B_BASE  = 8'd34;
  localparam logic [7:0]      DIV_BASE    = 8'd42;
  localparam logic [7:0]      CLK_CTRL    = 8'd16;
  localparam logic [7:0]      PLL_RST_ADR = 8'd177;
  localparam logic [7:0]      PLL_RST_DAT = 8'hA0;
  localparam logic [7:0]      CTRL_BASE   = 8'h0F;
  localparam logic [7:0]      CTRL_SRC_B  = 8'h20;
  localparam logic [7:0]      CTRL_INT    = 8'h40;

  typedef enum logic {
    ACT_PLL = 1'b0,
    ACT_DIV = 1'b1
  } action_t;

  typedef enum logic [3:0] {
    BT_P3_HI  = 4'd0,
    BT_P3_LO  = 4'd1,
    BT_P1_TOP = 4'd2,
    BT_P1_HI  = 4'd3,
    BT_P1_LO  = 4'd4,
    BT_MIX    = 4'd5,
    BT_P2_HI  = 4'd6,
    BT_P2_LO  = 4'd7,
    BT_CTRL   = 4'd8
  } beat_t;

  // Payload travelling down the divider row
  typedef struct packed {
    action_t          action;
    logic [1:0]       target;
    logic             source_pll;
    logic [INT_W-1:0] int_part;
    logic             num_zero;
    logic [NUM_W-1:0] den;
    logic [NUM_W-1:0] rem;
    logic [QD_W-1:0]  qd;     // dividend bits shift out on top, quotient bits in below
  } div_cell_t;

endpackage

`default_nettype wire

// ===== hdl/clock_synth_divider_encoder.sv =====
// An accepted request passes through the 27 division cells and is loaded into the
// encoder's parameter registers before its first write beat. Each request yields nine
//   writes on the result port; the 27-cell division row holds further requests meanwhile.
// Reset: rst_n synchronous, active low; clears all valid flags and the sequencer.
// ----------------------------------------------------------------------------
// clock_synth_divider_encoder: fractional divider to register write encoder
// A row of restoring-division cells yields 128b/c, then nine writes are emitted.
// ----------------------------------------------------------------------------
`default_nettype none

module clock_synth_divider_encoder (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [55:0] in_tdata,   // target[1:0], source_pll[2], int_part[13:3],
                                  // numerator[33:14], denominator[53:34], zero pad
  input  wire  [0:0]  in_tuser,   // action[0]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // reg_address[7:0], reg_data[15:8]
  output logic        out_tlast   // last_write
);
  import csde_pkg::*;

  logic      adv;
  logic      tail_ready;
  div_cell_t head;
  logic      vld  [NUM_CELLS+1];
  div_cell_t dat  [NUM_CELLS+1];

  always_comb begin
    head.action     = action_t'(in_tuser[0]);
    head.target     = in_tdata[1:0];
    head.source_pll = in_tdata[2];
    head.int_part   = in_tdata[13:3];
    head.num_zero   = (in_tdata[33:14] == '0);
    head.den        = in_tdata[53:34];
    head.rem        = '0;
    head.qd         = {in_tdata[33:14], FRAC_SH'(0)};
  end

  assign vld[0] = in_tvalid;
  assign dat[0] = head;

  // stall the whole row only while its last cell is held
  assign adv       = !vld[NUM_CELLS] || tail_ready;
  assign in_tready = adv;

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    csde_div_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .adv        (adv),
      .prev_valid (vld[i]),
      .prev       (dat[i]),
      .cell_valid (vld[i+1]),
      .cell_data  (dat[i+1])
    );
  end

  csde_encoder u_enc (
    .clk        (clk),
    .rst_n      (rst_n),
    .tail_valid (vld[NUM_CELLS]),
    .tail       (dat[NUM_CELLS]),
    .tail_ready (tail_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/csde_div_cell.sv =====
// ----------------------------------------------------------------------------
// csde_div_cell: one restoring-division step
// Takes the neighbor's partial remainder, develops one quotient bit, registers.
// ----------------------------------------------------------------------------
`default_nettype none

module csde_div_cell (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 adv,
  input  wire                 prev_valid,
  input  csde_pkg::div_cell_t prev,
  output logic                cell_valid,
  output csde_pkg::div_cell_t cell_data
);
  import csde_pkg::*;

  logic             valid_r;
  div_cell_t        data_r;
  div_cell_t        data_nxt;
  logic [NUM_W:0]   trial;
  logic [NUM_W-1:0] diff;
  logic             ge;

  always_comb begin
    trial    = {prev.rem, prev.qd[QD_W-1]};
    ge       = (trial >= {1'b0, prev.den});
    // the difference is below den whenever it is taken, so the low bits suffice
    diff     = trial[NUM_W-1:0] - prev.den;
    data_nxt = prev;
    data_nxt.rem = ge ? diff : trial[NUM_W-1:0];
    data_nxt.qd  = {prev.qd[QD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign cell_valid = valid_r;
  assign cell_data  = data_r;

endmodule

`default_nettype wire

// ===== hdl/csde_encoder.sv =====
// ----------------------------------------------------------------------------
// csde_encoder: parameter packing and write sequencer
// Forms P1/P2/P3 from the finished quotient and plays out nine register writes.
// ----------------------------------------------------------------------------
`default_nettype none

module csde_encoder (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 tail_valid,
  input  csde_pkg::div_cell_t tail,
  output logic                tail_ready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [15:0]         out_tdata,
  output logic                out_tlast
);
  import csde_pkg::*;

  logic             busy_r, busy_nxt;
  beat_t            cnt_r, cnt_nxt;
  logic [7:0]       base_r, base_nxt;
  logic [P1_W-1:0]  p1_r, p1_nxt;
  logic [NUM_W-1:0] p2_r, p2_nxt;
  logic [NUM_W-1:0] p3_r, p3_nxt;
  logic [7:0]       ctl_adr_r, ctl_adr_nxt;
  logic [7:0]       ctl_dat_r, ctl_dat_nxt;
  logic             load;
  logic             beat_done;
  logic [P1_W-1:0]  q_lo;
  logic [7:0]       reg_address;
  logic [7:0]       reg_data;

  always_comb begin
    beat_done  = busy_r && out_tready;
    tail_ready = !busy_r || (beat_done && (cnt_r == BT_CTRL));
    load       = tail_valid && tail_ready;

    // zero denominator drops the fraction
    q_lo   = (tail.den == '0) ? '0 : tail.qd[P1_W-1:0];
    p1_nxt = {tail.int_part, FRAC_SH'(0)} + q_lo - P1_OFFSET;
    p2_nxt = (tail.den == '0) ? '0 : tail.rem;
    p3_nxt = tail.den;

    if (tail.action == ACT_PLL) begin
      base_nxt    = (tail.target == 2'd0) ? PLL_A_BASE : PLL_B_BASE;
      ctl_adr_nxt = PLL_RST_ADR;
      ctl_dat_nxt = PLL_RST_DAT;
    end else begin
      base_nxt    = DIV_BASE + {3'b000, tail.target, 3'b000};
      ctl_adr_nxt = CLK_CTRL + {6'd0, tail.target};
      ctl_dat_nxt = CTRL_BASE | (tail.source_pll ? CTRL_SRC_B : 8'h00)
                  | (tail.num_zero ? CTRL_INT : 8'h00);
    end

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = BT_P3_HI;
    end else if (beat_done) begin
      if (cnt_r == BT_CTRL) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = beat_t'(cnt_r + 4'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= BT_P3_HI;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      base_r    <= base_nxt;
      p1_r      <= p1_nxt;
      p2_r      <= p2_nxt;
      p3_r      <= p3_nxt;
      ctl_adr_r <= ctl_adr_nxt;
      ctl_dat_r <= ctl_dat_nxt;
    end
  end

  // beat mux over the held parameter block
  always_comb begin
    reg_address = base_r + {4'd0, cnt_r};
    case (cnt_r)
      BT_P3_HI:  reg_data = p3_r[15:8];
      BT_P3_LO:  reg_data = p3_r[7:0];
      BT_P1_TOP: reg_data = {6'd0, p1_r[17:16]};
      BT_P1_HI:  reg_data = p1_r[15:8];
      BT_P1_LO:  reg_data = p1_r[7:0];
      BT_MIX:    reg_data = {p3_r[19:16], p2_r[19:16]};
      BT_P2_HI:  reg_data = p2_r[15:8];
      BT_P2_LO:  reg_data = p2_r[7:0];
      BT_CTRL: begin
        reg_address = ctl_adr_r;
        reg_data    = ctl_dat_r;
      end
      default:   reg_data = 8'h00;
    endcase
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = {reg_data, reg_address};
  assign out_tlast  = (cnt_r == BT_CTRL);

endmodule

`default_nettype wire

// ===== hdl/csde_checker.sv =====
// ----------------------------------------------------------------------------
// csde_checker: port-level checks of the divider register encoder
// Watches the result stream for reset behavior and the write sequence order.
// ----------------------------------------------------------------------------
`default_nettype none

module csde_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [15:0] out_tdata,
  input wire        out_tlast
);
  import csde_pkg::*;

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result beat changed");

  // block writes step by one; the final control write sits elsewhere
  a_addr_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tlast || (out_tdata[7:0] == $past(out_tdata[7:0]) + 8'd1)))
    else $error("block write address did not advance by one");

  a_ctrl_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      out_tdata[7:0] == PLL_RST_ADR || out_tdata[7:0] == CLK_CTRL ||
      out_tdata[7:0] == CLK_CTRL + 8'd1 || out_tdata[7:0] == CLK_CTRL + 8'd2 ||
      out_tdata[7:0] == CLK_CTRL + 8'd3)
    else $error("final write at unexpected address");

endmodule

bind clock_synth_divider_encoder csde_checker u_csde_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: divider register encoder check
// Drives PLL and output divider requests through the stream input, predicts
// the nine register writes of each request and checks every result beat.
// ----------------------------------------------------------------------------

module testbench;
  import csde_pkg::*;

  typedef struct packed {
    action_t     action;
    logic [1:0]  target;
    logic        source_pll;
    logic [10:0] int_part;
    logic [19:0] numerator;
    logic [19:0] denominator;
  } synth_req_t;

  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] data;
    logic       last;
  } reg_write_t;

  // Directed row: request plus the hand-read final control write
  typedef struct packed {
    synth_req_t req;
    logic [7:0] ctrl_addr;
    logic [7:0] ctrl_data;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;

  reg_write_t  pending_writes[$];
  dir_row_t    dir_rows[$];
  int          err_count;
  bit          sender_idle;
  bit          receiver_idle;

  clock_synth_divider_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2ms;
    $display("testbench: errors");
    $finish;
  end

  // Queue the nine writes that one request must produce
  function automatic void encode_writes(input synth_req_t req);
    logic [26:0] dividend;
    logic [26:0] quot;
    logic [26:0] rmd;
    logic [31:0] p1_full;
    logic [17:0] p1;
    logic [19:0] p2;
    logic [19:0] p3;
    logic [7:0]  base;
    logic [7:0]  ctrl_addr;
    logic [7:0]  ctrl_data;
    logic [7:0]  bytes[8];
    dividend = {req.numerator, 7'b0};
    quot = '0;
    rmd = '0;
    if (req.denominator != 0) begin
      quot = dividend / {7'b0, req.denominator};
      rmd = dividend % {7'b0, req.denominator};
    end
    p1_full = 32'(req.int_part) * 32'd128 + 32'(quot) - 32'(P1_OFFSET);
    p1 = p1_full[17:0];
    p2 = rmd[19:0];
    p3 = req.denominator;
    if (req.action == ACT_PLL) begin
      base = (req.target == 2'd0) ? PLL_A_BASE : PLL_B_BASE;
      ctrl_addr = PLL_RST_ADR;
      ctrl_data = PLL_RST_DAT;
    end else begin
      base = DIV_BASE + 8'(req.target) * 8'd8;
      ctrl_addr = CLK_CTRL + 8'(req.target);
      ctrl_data = CTRL_BASE;
      if (req.source_pll) ctrl_data |= CTRL_SRC_B;
      if (req.numerator == 0) ctrl_data |= CTRL_INT;
    end
    bytes[0] = p3[15:8];
    bytes[1] = p3[7:0];
    bytes[2] = {6'b0, p1[17:16]};
    bytes[3] = p1[15:8];
    bytes[4] = p1[7:0];
    bytes[5] = {p3[19:16], p2[19:16]};
    bytes[6] = p2[15:8];
    bytes[7] = p2[7:0];
    for (int k = 0; k < 8; k++) begin
      pending_writes.push_back('{addr: base + 8'(k), data: bytes[k], last: 1'b0});
    end
    pending_writes.push_back('{addr: ctrl_addr, data: ctrl_data, last: 1'b1});
  endfunction

  function automatic synth_req_t rand_request();
    synth_req_t req;
    req.action = ($urandom_range(0, 1) == 0) ? ACT_PLL : ACT_DIV;
    req.target = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    req.source_pll = 1'($urandom);
    case ($urandom_range(0, 3))
      0: req.int_part = 11'($urandom_range(0, 8));
      1: req.int_part = 11'd2047;
      default: req.int_part = 11'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: req.numerator = '0;
      1: req.numerator = 20'hFFFFF;
      2: req.numerator = 20'($urandom_range(1, 15));
      default: req.numerator = 20'($urandom);
    endcase
    case ($urandom_range(0, 4))
      0: req.denominator = 20'($urandom_range(1, 16));
      1: req.denominator = 20'hFFFFF;
      2: req.denominator = (req.numerator != 0) ? req.numerator : 20'd1;
      default: req.denominator = 20'($urandom);
    endcase
    if (req.denominator == 0) req.denominator = 20'd1;
    return req;
  endfunction

  // Present one request, hold until accepted, then queue its writes
  task automatic send_request(input synth_req_t req, input bit typed_ctrl,
                              input logic [7:0] ctrl_addr, input logic [7:0] ctrl_data);
    int gap;
    gap = sender_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata = {2'b0, req.denominator, req.numerator, req.int_part, req.source_pll,
                req.target};
    in_tuser = req.action;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    encode_writes(req);
    if (typed_ctrl) pending_writes[$] = '{addr: ctrl_addr, data: ctrl_data, last: 1'b1};
    @(negedge clk);
  endtask

  // Result side: while receiver_idle is set, drop ready for a random stall before each beat
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = receiver_idle ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    reg_write_t exp_wr;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected write beat: addr %0d data 0x%02h", out_tdata[7:0],
               out_tdata[15:8]);
        err_count++;
      end else begin
        exp_wr = pending_writes.pop_front();
        if (out_tdata[7:0] !== exp_wr.addr) begin
          $error("reg_address: expected %0d, got %0d", exp_wr.addr, out_tdata[7:0]);
          err_count++;
        end
        if (out_tdata[15:8] !== exp_wr.data) begin
          $error("reg_data: expected 0x%02h, got 0x%02h", exp_wr.data, out_tdata[15:8]);
          err_count++;
        end
        if (out_tlast !== exp_wr.last) begin
          $error("last_write: expected %0b, got %0b", exp_wr.last, out_tlast);
          err_count++;
        end
      end
    end
  end

  initial begin
    synth_req_t req;
    int waited;
    err_count = 0;
    sender_idle = 1'b1;
    receiver_idle = 1'b1;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;

    // Low integer parts wrap P1, numerators at or above the denominator
    // push the quotient past 127, channel three follows the common rule
    dir_rows.push_back('{'{ACT_PLL, 2'd0, 1'b0, 11'd0,    20'd0,      20'd1},
                         8'd177, 8'hA0});
    dir_rows.push_back('{'{ACT_PLL, 2'd1, 1'b0, 11'd2047, 20'hFFFFF,  20'hFFFFF},
                         8'd177, 8'hA0});
    dir_rows.push_back('{'{ACT_PLL, 2'd2, 1'b1, 11'd36,   20'hFFFFF,  20'd1},
                         8'd177, 8'hA0});
    dir_rows.push_back('{'{ACT_PLL, 2'd3, 1'b1, 11'd100,  20'd5,      20'd7},
                         8'd177, 8'hA0});
    dir_rows.push_back('{'{ACT_PLL, 2'd0, 1'b0, 11'd3,    20'd1,      20'hFFFFF},
                         8'd177, 8'hA0});
    dir_rows.push_back('{'{ACT_PLL, 2'd0, 1'b1, 11'd1,    20'd0,      20'hFFFFF},
                         8'd177, 8'hA0});
    dir_rows.push_back('{'{ACT_DIV, 2'd0, 1'b0, 11'd4,    20'd0,      20'd1},
                         8'd16, 8'h4F});
    dir_rows.push_back('{'{ACT_DIV, 2'd1, 1'b1, 11'd6,    20'd0,      20'd9},
                         8'd17, 8'h6F});
    dir_rows.push_back('{'{ACT_DIV, 2'd2, 1'b0, 11'd8,    20'd1,      20'hFFFFF},
                         8'd18, 8'h0F});
    dir_rows.push_back('{'{ACT_DIV, 2'd3, 1'b1, 11'd900,  20'd12345,  20'd99999},
                         8'd19, 8'h2F});
    dir_rows.push_back('{'{ACT_DIV, 2'd3, 1'b0, 11'd2,    20'd0,      20'd3},
                         8'd19, 8'h4F});
    dir_rows.push_back('{'{ACT_DIV, 2'd0, 1'b1, 11'd2047, 20'hFFFFF,  20'hFFFFF},
                         8'd16, 8'h2F});
    dir_rows.push_back('{'{ACT_DIV, 2'd2, 1'b0, 11'd0,    20'd1,      20'd2},
                         8'd18, 8'h0F});
    dir_rows.push_back('{'{ACT_DIV, 2'd1, 1'b0, 11'd512,  20'd699050, 20'd699051},
                         8'd17, 8'h0F});
    dir_rows.push_back('{'{ACT_DIV, 2'd2, 1'b1, 11'd1024, 20'd524288, 20'd524288},
                         8'd18, 8'h2F});
    dir_rows.push_back('{'{ACT_DIV, 2'd1, 1'b1, 11'd1365, 20'hAAAAA,  20'h55555},
                         8'd17, 8'h2F});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req, 1'b1, dir_rows[i].ctrl_addr, dir_rows[i].ctrl_data);
    end

    // Switch idle pattern every 40 requests, including runs with no gaps at all
    for (int n = 0; n < 400; n++) begin
      if (n % 40 == 0) begin
        sender_idle = 1'($urandom);
        receiver_idle = 1'($urandom);
      end
      req = rand_request();
      send_request(req, 1'b0, 8'd0, 8'd0);
    end
    in_tvalid = 1'b0;

    waited = 0;
    while (pending_writes.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (err_count == 0 && pending_writes.size() == 0) begin
      $display("testbench: clean");
    end else begin
      if (pending_writes.size() != 0) begin
        $error("%0d register writes never arrived", pending_writes.size());
      end
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
